// ===== hw/rtl/gmsp_pkg.sv =====
package gmsp_pkg;

  // Default board width limit
  localparam int unsigned DEF_MAX_COLS = 128;

  // Field widths
  localparam int unsigned CODE_W   = 4;
  localparam int unsigned SCORE_W  = 12;
  localparam int unsigned COUNT_W  = 30;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned NCOL_W   = 8;

  // Path count modulus and score ceiling
  localparam logic [COUNT_W-1:0] PATH_MOD  = COUNT_W'(1000000007);
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  // Cell codes
  localparam logic [CODE_W-1:0] CODE_DIGIT_MAX = CODE_W'(9);
  localparam logic [CODE_W-1:0] CODE_OBSTACLE  = CODE_W'(10);

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_FOUND   = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_NO_PATH = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_CORNER  = STATUS_W'(2);

  // One row store entry: best score and number of best paths
  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] score;
    logic [COUNT_W-1:0] count;
  } entry_t;

endpackage

// ===== hw/rtl/gmsp_merge.sv =====
module gmsp_merge (
  input  gmsp_pkg::entry_t                    up_i,
  input  gmsp_pkg::entry_t                    left_i,
  input  gmsp_pkg::entry_t                    diag_i,
  input  logic [gmsp_pkg::CODE_W-1:0]         code_i,
  input  logic                                add_en_i,
  output gmsp_pkg::entry_t                    merged_o
);
  import gmsp_pkg::*;

  localparam logic [31:0] MOD_1X = 32'(PATH_MOD);
  localparam logic [31:0] MOD_2X = 32'(PATH_MOD) << 1;

  logic [SCORE_W-1:0] best;
  logic               any_valid;
  logic [31:0]        sum;
  logic [31:0]        sum_red;
  logic [SCORE_W:0]   score_add;

  // Largest score among valid neighbors
  always_comb begin
    best = '0;
    if (up_i.valid && up_i.score > best) begin
      best = up_i.score;
    end
    if (left_i.valid && left_i.score > best) begin
      best = left_i.score;
    end
    if (diag_i.valid && diag_i.score > best) begin
      best = diag_i.score;
    end
  end

  assign any_valid = up_i.valid | left_i.valid | diag_i.valid;

  // Sum counts of neighbors at the best score, then reduce mod PATH_MOD
  assign sum = ((up_i.valid && up_i.score == best) ? 32'(up_i.count) : 32'd0) +
               ((left_i.valid && left_i.score == best) ? 32'(left_i.count) : 32'd0) +
               ((diag_i.valid && diag_i.score == best) ? 32'(diag_i.count) : 32'd0);

  always_comb begin
    if (sum >= MOD_2X) begin
      sum_red = sum - MOD_2X;
    end else if (sum >= MOD_1X) begin
      sum_red = sum - MOD_1X;
    end else begin
      sum_red = sum;
    end
  end

  // Add the digit, saturating
  always_comb begin
    score_add = {1'b0, best};
    if (add_en_i && code_i <= CODE_DIGIT_MAX) begin
      score_add = {1'b0, best} + (SCORE_W+1)'(code_i);
    end
  end

  always_comb begin
    merged_o.valid = any_valid;
    merged_o.count = sum_red[COUNT_W-1:0];
    merged_o.score = score_add[SCORE_W] ? SCORE_MAX : score_add[SCORE_W-1:0];
  end

endmodule

// ===== hw/rtl/grid_max_score_path_counter.sv =====
// out_valid rises as the last cell passes from the stage into the result register.
// Throughput: one cell per cycle; the row store is read when a cell is taken and written
// back as the cell leaves the stage, with a forwarding register for same-column access.
// Only a last cell can wait in the stage, holding in_stall, while a result is still held.
// Reset (rst_n low, synchronous): sweep state and channels clear, num_columns is 1.
// The row store is not cleared; the first row ignores what it reads from it.
module grid_max_score_path_counter #(
  parameter int unsigned MAX_COLS = gmsp_pkg::DEF_MAX_COLS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [gmsp_pkg::NCOL_W-1:0]        cfg_num_columns,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [gmsp_pkg::CODE_W-1:0]        in_cell_code,
  input  logic                               in_last_cell,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gmsp_pkg::SCORE_W-1:0]       out_max_score,
  output logic [gmsp_pkg::COUNT_W-1:0]       out_path_count,
  output logic [gmsp_pkg::STATUS_W-1:0]      out_path_status
);
  import gmsp_pkg::*;

  localparam int unsigned COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CMP_W = (COL_W + 1 > NCOL_W) ? COL_W + 1 : NCOL_W;
  localparam logic [CMP_W-1:0] MAX_COLS_C = CMP_W'(MAX_COLS);

  // Configuration register
  logic [NCOL_W-1:0] num_cols_r;

  // Sweep control state
  logic [COL_W-1:0]  col_pos_r;
  logic              first_row_r;
  logic              corner_blocked_r;
  entry_t            left_r;
  entry_t            diag_r;

  // Second stage
  logic              s1_valid_r;
  logic [CODE_W-1:0] s1_code_r;
  logic              s1_last_r;
  logic [COL_W-1:0]  s1_col_r;
  logic              s1_first_row_r;
  logic              s1_is_first_r;
  logic              s1_wrap_r;

  // Row store and forwarding
  entry_t            row_mem [MAX_COLS];
  entry_t            rd_data_r;
  logic              fwd_hit_r;
  entry_t            fwd_entry_r;

  // Output register
  logic                out_valid_r;
  logic [SCORE_W-1:0]  out_score_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [STATUS_W-1:0] out_status_r;

  logic              s1_fire;
  logic              in_xfer;
  logic [CMP_W-1:0]  cols_eff;
  logic [CMP_W-1:0]  col_next_ext;
  logic              wrap_now;
  logic              obstacle;
  logic              blocked_now;
  entry_t            up_raw;
  entry_t            up;
  entry_t            left_m;
  entry_t            diag_m;
  entry_t            merged;
  entry_t            cur;

  // Handshake
  assign s1_fire  = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_xfer  = in_valid && !in_stall;

  // Effective column count, clamped to 1..MAX_COLS
  always_comb begin
    cols_eff = CMP_W'(num_cols_r);
    if (num_cols_r == '0) begin
      cols_eff = CMP_W'(1);
    end else if (cols_eff > MAX_COLS_C) begin
      cols_eff = MAX_COLS_C;
    end
  end

  assign col_next_ext = CMP_W'(col_pos_r) + CMP_W'(1);
  assign wrap_now     = col_next_ext >= cols_eff;

  // Configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= NCOL_W'(1);
    end else if (cfg_wr_en) begin
      num_cols_r <= cfg_num_columns;
    end
  end

  // Column tracking at transfer time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r   <= '0;
      first_row_r <= 1'b1;
    end else if (in_xfer) begin
      if (in_last_cell) begin
        col_pos_r   <= '0;
        first_row_r <= 1'b1;
      end else if (wrap_now) begin
        col_pos_r   <= '0;
        first_row_r <= 1'b0;
      end else begin
        col_pos_r   <= col_next_ext[COL_W-1:0];
      end
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_code_r      <= in_cell_code;
      s1_last_r      <= in_last_cell;
      s1_col_r       <= col_pos_r;
      s1_first_row_r <= first_row_r;
      s1_is_first_r  <= first_row_r && (col_pos_r == '0);
      s1_wrap_r      <= wrap_now;
      fwd_hit_r      <= s1_fire && (s1_col_r == col_pos_r);
      fwd_entry_r    <= cur;
    end
  end

  // Row store: read on transfer, write back when the stage completes
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      row_mem[s1_col_r] <= cur;
    end
    if (in_xfer) begin
      rd_data_r <= row_mem[col_pos_r];
    end
  end

  // Neighbor selection
  always_comb begin
    up_raw = fwd_hit_r ? fwd_entry_r : rd_data_r;
    up     = s1_first_row_r ? entry_t'('0) : up_raw;
    left_m = left_r;
    diag_m = diag_r;
    left_m.valid = left_r.valid && (s1_col_r != '0);
    diag_m.valid = diag_r.valid && (s1_col_r != '0) && !s1_first_row_r;
  end

  gmsp_merge u_merge (
    .up_i     (up),
    .left_i   (left_m),
    .diag_i   (diag_m),
    .code_i   (s1_code_r),
    .add_en_i (!s1_last_r),
    .merged_o (merged)
  );

  // Current cell entry
  assign obstacle    = (s1_code_r == CODE_OBSTACLE);
  assign blocked_now = corner_blocked_r || (obstacle && (s1_is_first_r || s1_last_r));

  always_comb begin
    if (obstacle) begin
      cur = '0;
    end else if (s1_is_first_r) begin
      cur = '0;
      cur.valid = 1'b1;
      cur.count = COUNT_W'(1);
    end else begin
      cur = merged;
    end
  end

  // Left/diag neighbors and corner flag update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r           <= '0;
      diag_r           <= '0;
      corner_blocked_r <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last_r || s1_wrap_r) begin
        left_r <= '0;
        diag_r <= '0;
      end else begin
        left_r <= cur;
        diag_r <= up;
      end
      corner_blocked_r <= s1_last_r ? 1'b0 : blocked_now;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      if (blocked_now) begin
        out_score_r  <= '0;
        out_count_r  <= '0;
        out_status_r <= STATUS_CORNER;
      end else if (!cur.valid) begin
        out_score_r  <= '0;
        out_count_r  <= '0;
        out_status_r <= STATUS_NO_PATH;
      end else begin
        out_score_r  <= cur.score;
        out_count_r  <= cur.count;
        out_status_r <= STATUS_FOUND;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_max_score   = out_score_r;
  assign out_path_count  = out_count_r;
  assign out_path_status = out_status_r;

endmodule

// ===== bench/path_result_checker.sv =====
`timescale 1ns / 1ps

module path_result_checker #(
  parameter int unsigned MAX_COLS = gmsp_pkg::DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [gmsp_pkg::NCOL_W-1:0]   cfg_num_columns,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [gmsp_pkg::CODE_W-1:0]   in_cell_code,
  input  logic                          in_last_cell,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [gmsp_pkg::SCORE_W-1:0]  out_max_score,
  input  logic [gmsp_pkg::COUNT_W-1:0]  out_path_count,
  input  logic [gmsp_pkg::STATUS_W-1:0] out_path_status,
  output int                            mismatches,
  output int                            results_owed
);
  import gmsp_pkg::*;

  typedef struct packed {
    logic [SCORE_W-1:0]  score;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } board_result_t;

  // Shadow of the sweep state
  logic [NCOL_W-1:0] board_cols;
  entry_t            prev_row [MAX_COLS];
  entry_t            left_cell;
  entry_t            diag_cell;
  int unsigned       sweep_col;
  bit                top_row;
  bit                corner_hit;

  // Board results still to come out, oldest first
  board_result_t     results_due [$];

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // Keep the better of two partial paths; ties add their counts mod PATH_MOD
  function automatic entry_t fold_neighbor(entry_t acc, entry_t nb);
    logic [COUNT_W:0] sum;
    if (!nb.valid)
      return acc;
    if (!acc.valid || nb.score > acc.score)
      return nb;
    if (nb.score == acc.score) begin
      sum = {1'b0, acc.count} + {1'b0, nb.count};
      if (sum >= {1'b0, PATH_MOD})
        sum = sum - {1'b0, PATH_MOD};
      acc.count = sum[COUNT_W-1:0];
    end
    return acc;
  endfunction

  task automatic restart_sweep();
    left_cell  = '0;
    diag_cell  = '0;
    sweep_col  = 0;
    top_row    = 1'b1;
    corner_hit = 1'b0;
  endtask

  // One cell of the forward sweep; queues a result on the board's last cell
  task automatic take_cell(input logic [CODE_W-1:0] code, input logic last);
    int unsigned      eff_cols;
    int unsigned      col;
    bit               at_origin;
    entry_t           above;
    entry_t           here;
    board_result_t    res;
    logic [SCORE_W:0] raised;
    if (board_cols == 0)
      eff_cols = 1;
    else if (board_cols > MAX_COLS)
      eff_cols = MAX_COLS;
    else
      eff_cols = 32'(board_cols);
    col       = sweep_col;
    at_origin = (col == 0) && top_row;
    above     = '0;
    if (!top_row)
      above = prev_row[col];
    here = '0;

    if (code == CODE_OBSTACLE) begin
      if (at_origin || last)
        corner_hit = 1'b1;
    end else if (at_origin) begin
      here.valid = 1'b1;
      here.count = COUNT_W'(1);
    end else begin
      here = fold_neighbor(here, above);
      if (col > 0) begin
        here = fold_neighbor(here, left_cell);
        if (!top_row)
          here = fold_neighbor(here, diag_cell);
      end
      // corners and non-digit codes add nothing; score saturates
      if (here.valid && !last && code <= CODE_DIGIT_MAX) begin
        raised     = {1'b0, here.score} + (SCORE_W+1)'(code);
        here.score = raised[SCORE_W] ? SCORE_MAX : raised[SCORE_W-1:0];
      end
    end
    prev_row[col] = here;

    if (last) begin
      if (corner_hit)
        res = '{score: '0, count: '0, status: STATUS_CORNER};
      else if (!here.valid)
        res = '{score: '0, count: '0, status: STATUS_NO_PATH};
      else
        res = '{score: here.score, count: here.count, status: STATUS_FOUND};
      results_due.push_back(res);
      restart_sweep();
    end else if (col + 1 >= eff_cols) begin
      // row wrap
      sweep_col = 0;
      top_row   = 1'b0;
      left_cell = '0;
      diag_cell = '0;
    end else begin
      diag_cell = above;
      left_cell = here;
      sweep_col = col + 1;
    end
  endtask

  // Watch both channels and the config port at each rising edge
  always @(posedge clk) begin
    board_result_t want;
    if (!rst_n) begin
      board_cols = NCOL_W'(1);
      restart_sweep();
      results_due.delete();
    end else begin
      if (cfg_wr_en)
        board_cols = cfg_num_columns;
      if (in_valid && !in_stall)
        take_cell(in_cell_code, in_last_cell);
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: score %0d count %0d status %0d",
                                    out_max_score, out_path_count, out_path_status));
        end else begin
          want = results_due.pop_front();
          if (out_max_score !== want.score)
            report_mismatch($sformatf("max_score got %0d want %0d", out_max_score, want.score));
          if (out_path_count !== want.count)
            report_mismatch($sformatf("path_count got %0d want %0d", out_path_count, want.count));
          if (out_path_status !== want.status)
            report_mismatch($sformatf("path_status got %0d want %0d",
                                      out_path_status, want.status));
        end
      end
    end
    results_owed = results_due.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import gmsp_pkg::*;

  localparam int unsigned CLK_HIGH_NS       = 6;
  localparam int unsigned CLK_LOW_NS        = 6;
  localparam int unsigned RESET_CYCLES      = 10;
  localparam int unsigned SETTLE_CYCLES     = 4;
  localparam int unsigned HOLD_OFF_CYCLES   = 300;
  localparam int unsigned HOLD_OFF_BOARDS   = 40;
  localparam int unsigned CELL_TARGET       = 1750;
  localparam int unsigned MIN_RANDOM_BOARDS = 20;
  localparam int unsigned DRAIN_LIMIT       = 20000;
  localparam int unsigned SAT_ROWS          = 460;
  localparam int unsigned TIE_SIDE          = 14;
  localparam longint unsigned RUN_LIMIT_NS  = 64'd8_000_000;

  // Cell codes beyond the package's digits and obstacle
  localparam logic [CODE_W-1:0] CODE_MARKER = CODE_W'(11);
  localparam logic [CODE_W-1:0] CODE_TOP    = CODE_W'(15);

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                cfg_wr_en       = 1'b0;
  logic [NCOL_W-1:0]   cfg_num_columns = '0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [CODE_W-1:0]   in_cell_code    = '0;
  logic                in_last_cell    = 1'b0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [SCORE_W-1:0]  out_max_score;
  logic [COUNT_W-1:0]  out_path_count;
  logic [STATUS_W-1:0] out_path_status;

  int                  mismatches;
  int                  results_owed;
  bit                  hold_req        = 1'b0;
  int unsigned         cells_sent      = 0;
  int unsigned         eff_cols        = 1;
  logic [CODE_W-1:0]   board_cells [$];

  always begin
    #CLK_LOW_NS clk = 1'b1;
    #CLK_HIGH_NS clk = 1'b0;
  end

  grid_max_score_path_counter u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_num_columns (cfg_num_columns),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cell_code    (in_cell_code),
    .in_last_cell    (in_last_cell),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_max_score   (out_max_score),
    .out_path_count  (out_path_count),
    .out_path_status (out_path_status)
  );

  path_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_num_columns (cfg_num_columns),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cell_code    (in_cell_code),
    .in_last_cell    (in_last_cell),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_max_score   (out_max_score),
    .out_path_count  (out_path_count),
    .out_path_status (out_path_status),
    .mismatches      (mismatches),
    .results_owed    (results_owed)
  );

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 85)
      return $urandom_range(1, 3);
    if (roll < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one cell and hold it until the transfer
  task automatic send_cell(input logic [CODE_W-1:0] code, input logic last, input bit steady);
    int unsigned gap;
    gap = (steady || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     = 1'b1;
    in_cell_code = code;
    in_last_cell = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cells_sent++;
  endtask

  task automatic send_board(input bit steady);
    int unsigned k;
    for (k = 0; k < board_cells.size(); k++)
      send_cell(board_cells[k], k == board_cells.size() - 1, steady);
  endtask

  // Column count changes only once the block has gone idle
  task automatic configure_columns(input logic [NCOL_W-1:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en       = 1'b1;
    cfg_num_columns = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (value == 0)
      eff_cols = 1;
    else if (value > DEF_MAX_COLS)
      eff_cols = DEF_MAX_COLS;
    else
      eff_cols = 32'(value);
  endtask

  // Random board of the current width; sometimes ends early
  task automatic build_random_board(input int unsigned rows);
    int unsigned n, k, roll;
    board_cells.delete();
    n = rows * eff_cols;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 15)
        board_cells.push_back(CODE_OBSTACLE);
      else if (roll < 85)
        board_cells.push_back(CODE_W'($urandom_range(0, CODE_DIGIT_MAX)));
      else
        board_cells.push_back(CODE_W'($urandom_range(CODE_MARKER, CODE_TOP)));
    end
    // corners usually carry the marker
    if ($urandom_range(0, 9) < 8)
      board_cells[0] = CODE_MARKER;
    if ($urandom_range(0, 9) < 8)
      board_cells[n - 1] = CODE_MARKER;
    if (n > 1 && $urandom_range(0, 9) == 0) begin
      k = $urandom_range(1, n - 1);
      while (board_cells.size() > k) void'(board_cells.pop_back());
    end
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off on request
  initial begin : receiver
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned roll;
    bit          held;
    stall_left = 0;
    calm_left  = 0;
    held       = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held       = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && calm_left == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 10)
          calm_left = $urandom_range(20, 150);
        else if (roll < 40)
          stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if (calm_left > 0)
          calm_left--;
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int unsigned       k;
    int unsigned       boards;
    int unsigned       phase;
    int unsigned       n_boards;
    int unsigned       roll;
    logic [NCOL_W-1:0] setting;
    boards = 0;
    phase  = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Reset width of one column: single cell, blocked single cell, cut-off column
    board_cells = '{CODE_MARKER};
    send_board(1'b1);
    board_cells = '{CODE_OBSTACLE};
    send_board(1'b0);
    board_cells = '{CODE_MARKER, CODE_OBSTACLE, CODE_MARKER};
    send_board(1'b1);

    // Three columns: digit extremes, inner marker, spare code, blocked corners
    configure_columns(NCOL_W'(3));
    board_cells = '{CODE_MARKER, 4'd9, 4'd0, CODE_TOP, CODE_OBSTACLE, CODE_MARKER,
                    4'd5, 4'd3, CODE_MARKER};
    send_board(1'b0);
    board_cells = '{CODE_OBSTACLE, 4'd4, 4'd4, 4'd1, 4'd2, CODE_MARKER};
    send_board(1'b1);
    board_cells = '{CODE_MARKER, 4'd1, 4'd2, 4'd3, 4'd4, CODE_OBSTACLE};
    send_board(1'b0);

    // Receiver holds off while single-cell boards keep coming
    configure_columns(NCOL_W'(1));
    hold_req = 1'b1;
    for (k = 0; k < HOLD_OFF_BOARDS; k++) begin
      board_cells = '{CODE_W'($urandom_range(0, CODE_TOP))};
      send_board(1'b1);
    end

    // Every path ties at zero, so the count wraps the modulus
    configure_columns(NCOL_W'(TIE_SIDE));
    board_cells.delete();
    for (k = 0; k < TIE_SIDE * TIE_SIDE; k++)
      board_cells.push_back(($urandom_range(0, 3) == 0) ?
                            CODE_W'($urandom_range(CODE_MARKER, CODE_TOP)) : CODE_W'(0));
    send_board(1'b0);

    // Long two-column board of nines: all paths saturate and tie
    configure_columns(NCOL_W'(2));
    board_cells.delete();
    for (k = 0; k < 2 * SAT_ROWS; k++)
      board_cells.push_back(CODE_DIGIT_MAX);
    board_cells[0]                      = CODE_MARKER;
    board_cells[board_cells.size() - 1] = CODE_MARKER;
    send_board(1'b0);

    // Random phases: width extremes first, then mostly narrow boards
    while (cells_sent < CELL_TARGET || boards < MIN_RANDOM_BOARDS) begin
      case (phase)
        0: setting = '0;
        1: setting = NCOL_W'(DEF_MAX_COLS);
        2: setting = '1;
        default: begin
          roll = $urandom_range(0, 99);
          if (roll < 75)
            setting = NCOL_W'($urandom_range(1, 6));
          else if (roll < 90)
            setting = NCOL_W'($urandom_range(7, 16));
          else if (roll < 95)
            setting = NCOL_W'($urandom_range(17, 64));
          else
            setting = NCOL_W'($urandom_range(DEF_MAX_COLS + 1, 255));
        end
      endcase
      configure_columns(setting);
      n_boards = (eff_cols > 16) ? 1 : $urandom_range(2, 6);
      for (k = 0; k < n_boards; k++) begin
        if (eff_cols > 16)
          build_random_board((setting == '1) ? 1 : $urandom_range(1, 2));
        else
          build_random_board($urandom_range(1, 6));
        send_board($urandom_range(0, 3) == 0);
        boards++;
      end
      phase++;
    end

    // Drain and give the verdict
    @(negedge clk);
    in_valid = 1'b0;
    k = 0;
    while (results_owed != 0 && k < DRAIN_LIMIT) begin
      @(negedge clk);
      k++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && results_owed == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
